// ===== sv/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared constants, tables and types of the direction-cosine converter.
// ----------------------------------------------------------------------------
package dcm_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int SQ_STEPS      = FRAC_BITS + 1;
    localparam int CO_STEPS      = 17;
    localparam int PRESCALE_BITS = 16;
    localparam int LANES         = 3;

    localparam logic [31:0] ONE_SQ = 32'd1 << (2 * FRAC_BITS);

    localparam logic [18:0] ACC_FULL90 = 19'd368640;
    localparam logic signed [14:0] OUT_FULL90 = 15'sd11520;

    // atan(2^-i) in 1/4096 degree
    localparam logic [17:0] ATAN_TAB [0:CO_STEPS-1] = '{
        18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331,
        18'd3667, 18'd1833, 18'd917, 18'd458, 18'd229, 18'd115, 18'd57,
        18'd29, 18'd14, 18'd7, 18'd4
    };

    typedef struct packed {
        logic perr;   // pitch argument beyond one
        logic czero;  // cos(pitch) zero or undefined
        logic yerr;   // yaw argument beyond one
        logic rerr;   // roll argument beyond one
        logic n02;
        logic n01;
        logic n12;
    } flags_t;

endpackage

// ===== sv/dcm_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// dcm_to_euler_angles
// Pipelined conversion of three direction-cosine entries to pitch, yaw and
// roll in 1/128 degree (asin form), via integer square root and CORDIC.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  s_      | in  | r_row0_col2, r_row0_col1, r_row1_col2      | -
//  m_      | out | pitch_deg, yaw_deg, roll_deg, 3 zero bits  | domain_error
//
//  One request enters per cycle while the output is not stalled. The squares
//  register loads at the accepting edge, then come argument check,
//  15 square-root stages (one result bit each), prescale, 17 CORDIC stages
//  (one micro-rotation each) and the output register, which drives m_tvalid.
//  Reset clears only the valid bits of every stage.
//  A stalled output freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
module dcm_to_euler_angles
    import dcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // r_row0_col2, r_row0_col1, r_row1_col2
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pitch_deg, yaw_deg, roll_deg, zero pad
    output logic        m_tuser    // domain_error
);

    // whole pipeline moves when the output slot is free or being taken
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------ stage A
    logic signed [15:0] r02, r01, r12;
    logic [15:0] m02, m01, m12;
    assign r02 = s_tdata[15:0];
    assign r01 = s_tdata[31:16];
    assign r12 = s_tdata[47:32];
    assign m02 = r02[15] ? 16'(-r02) : r02;
    assign m01 = r01[15] ? 16'(-r01) : r01;
    assign m12 = r12[15] ? 16'(-r12) : r12;

    logic        a_v_reg;
    logic [31:0] a_sq02_reg, a_sq01_reg, a_sq12_reg;
    logic [15:0] a_m02_reg, a_m01_reg, a_m12_reg;
    logic        a_n02_reg, a_n01_reg, a_n12_reg;

    // ------------------------------------------------------------ stage B
    logic        b_perr, b_czero, b_yerr, b_rerr;
    logic [31:0] b_rest;
    logic [28:0] b_dp, b_dy, b_dr;
    flags_t      b_fl;

    always_comb
    begin
        b_perr  = a_sq02_reg > ONE_SQ;
        b_czero = a_sq02_reg >= ONE_SQ;
        b_rest  = ONE_SQ - a_sq02_reg;
        b_yerr  = !b_czero && (a_sq01_reg > b_rest);
        b_rerr  = !b_czero && (a_sq12_reg > b_rest);
        b_dp    = b_perr ? 29'd0 : 29'(b_rest);
        b_dy    = (b_czero || b_yerr) ? 29'd0 : 29'(b_rest - a_sq01_reg);
        b_dr    = (b_czero || b_rerr) ? 29'd0 : 29'(b_rest - a_sq12_reg);
        b_fl    = '{perr: b_perr, czero: b_czero, yerr: b_yerr, rerr: b_rerr,
                    n02: a_n02_reg, n01: a_n01_reg, n12: a_n12_reg};
    end

    // ------------------------------------------------- square-root stages
    logic        sr_v_reg   [0:SQ_STEPS];
    logic [28:0] sr_rem_reg [0:SQ_STEPS][0:LANES-1];
    logic [29:0] sr_res_reg [0:SQ_STEPS][0:LANES-1];
    logic [15:0] sr_mag_reg [0:SQ_STEPS][0:LANES-1];
    flags_t      sr_fl_reg  [0:SQ_STEPS];

    logic [28:0] sr_rem_next [1:SQ_STEPS][0:LANES-1];
    logic [29:0] sr_res_next [1:SQ_STEPS][0:LANES-1];

    always_comb
    begin
        logic [29:0] bitv;
        logic [29:0] trial;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            bitv = 30'd1 << (2 * (SQ_STEPS - 1 - k));
            for (int l = 0; l < LANES; l++)
            begin
                trial = sr_res_reg[k][l] + bitv;
                if ({1'b0, sr_rem_reg[k][l]} >= trial)
                begin
                    sr_rem_next[k+1][l] = 29'({1'b0, sr_rem_reg[k][l]} - trial);
                    sr_res_next[k+1][l] = (sr_res_reg[k][l] >> 1) + bitv;
                end
                else
                begin
                    sr_rem_next[k+1][l] = sr_rem_reg[k][l];
                    sr_res_next[k+1][l] = sr_res_reg[k][l] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------- CORDIC stages
    logic               co_v_reg  [0:CO_STEPS];
    logic signed [33:0] co_x_reg  [0:CO_STEPS][0:LANES-1];
    logic signed [33:0] co_y_reg  [0:CO_STEPS][0:LANES-1];
    logic signed [20:0] co_z_reg  [0:CO_STEPS][0:LANES-1];
    flags_t             co_fl_reg [0:CO_STEPS];

    logic signed [33:0] co_x_next [1:CO_STEPS][0:LANES-1];
    logic signed [33:0] co_y_next [1:CO_STEPS][0:LANES-1];
    logic signed [20:0] co_z_next [1:CO_STEPS][0:LANES-1];

    always_comb
    begin
        logic signed [33:0] dx, dy;
        logic signed [20:0] ang;
        for (int i = 0; i < CO_STEPS; i++)
        begin
            ang = $signed({3'b000, ATAN_TAB[i]});
            for (int l = 0; l < LANES; l++)
            begin
                dx = co_y_reg[i][l] >>> i;
                dy = co_x_reg[i][l] >>> i;
                if (!co_y_reg[i][l][33])
                begin
                    co_x_next[i+1][l] = co_x_reg[i][l] + dx;
                    co_y_next[i+1][l] = co_y_reg[i][l] - dy;
                    co_z_next[i+1][l] = co_z_reg[i][l] + ang;
                end
                else
                begin
                    co_x_next[i+1][l] = co_x_reg[i][l] - dx;
                    co_y_next[i+1][l] = co_y_reg[i][l] + dy;
                    co_z_next[i+1][l] = co_z_reg[i][l] - ang;
                end
            end
        end
    end

    // -------------------------------------------------------- output stage
    logic signed [14:0] ang_out [0:LANES-1];

    always_comb
    begin
        logic [18:0] zc;
        logic [18:0] rnd;
        for (int l = 0; l < LANES; l++)
        begin
            // clamp to [0, 90 deg], round half up to 1/128 degree
            if (co_z_reg[CO_STEPS][l][20])
                zc = 19'd0;
            else if (co_z_reg[CO_STEPS][l] > $signed({2'b00, ACC_FULL90}))
                zc = ACC_FULL90;
            else
                zc = co_z_reg[CO_STEPS][l][18:0];
            rnd = zc + 19'd16;
            ang_out[l] = $signed({1'b0, rnd[18:5]});
        end
    end

    flags_t             o_fl;
    logic signed [14:0] pitch_next, yaw_next, roll_next;
    logic               err_next;

    always_comb
    begin
        o_fl = co_fl_reg[CO_STEPS];
        if (o_fl.perr)
            pitch_next = o_fl.n02 ? OUT_FULL90 : -OUT_FULL90;
        else
            pitch_next = o_fl.n02 ? ang_out[0] : -ang_out[0];
        if (o_fl.czero || o_fl.yerr)
            yaw_next = o_fl.n01 ? -OUT_FULL90 : OUT_FULL90;
        else
            yaw_next = o_fl.n01 ? -ang_out[1] : ang_out[1];
        if (o_fl.czero || o_fl.rerr)
            roll_next = o_fl.n12 ? -OUT_FULL90 : OUT_FULL90;
        else
            roll_next = o_fl.n12 ? -ang_out[2] : ang_out[2];
        err_next = o_fl.perr || o_fl.czero || o_fl.yerr || o_fl.rerr;
    end

    logic        out_v_reg;
    logic [47:0] out_data_reg;
    logic        out_err_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // ------------------------------------------------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
                sr_v_reg[k] <= 1'b0;
            for (int i = 0; i <= CO_STEPS; i++)
                co_v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg     <= s_tvalid;
            sr_v_reg[0] <= a_v_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
                sr_v_reg[k] <= sr_v_reg[k-1];
            co_v_reg[0] <= sr_v_reg[SQ_STEPS];
            for (int i = 1; i <= CO_STEPS; i++)
                co_v_reg[i] <= co_v_reg[i-1];
            out_v_reg   <= co_v_reg[CO_STEPS];
        end
    end

    // ------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sq02_reg <= m02 * m02;
            a_sq01_reg <= m01 * m01;
            a_sq12_reg <= m12 * m12;
            a_m02_reg  <= m02;
            a_m01_reg  <= m01;
            a_m12_reg  <= m12;
            a_n02_reg  <= r02[15];
            a_n01_reg  <= r01[15];
            a_n12_reg  <= r12[15];

            sr_rem_reg[0][0] <= b_dp;
            sr_rem_reg[0][1] <= b_dy;
            sr_rem_reg[0][2] <= b_dr;
            sr_mag_reg[0][0] <= a_m02_reg;
            sr_mag_reg[0][1] <= a_m01_reg;
            sr_mag_reg[0][2] <= a_m12_reg;
            sr_fl_reg[0]     <= b_fl;
            for (int l = 0; l < LANES; l++)
                sr_res_reg[0][l] <= 30'd0;

            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sr_fl_reg[k] <= sr_fl_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    sr_rem_reg[k][l] <= sr_rem_next[k][l];
                    sr_res_reg[k][l] <= sr_res_next[k][l];
                    sr_mag_reg[k][l] <= sr_mag_reg[k-1][l];
                end
            end

            // prescale both operands by 2^16
            co_fl_reg[0] <= sr_fl_reg[SQ_STEPS];
            for (int l = 0; l < LANES; l++)
            begin
                co_x_reg[0][l] <= $signed({3'b000,
                    sr_res_reg[SQ_STEPS][l][FRAC_BITS:0], {PRESCALE_BITS{1'b0}}});
                co_y_reg[0][l] <= $signed({2'b00, sr_mag_reg[SQ_STEPS][l],
                    {PRESCALE_BITS{1'b0}}});
                co_z_reg[0][l] <= 21'sd0;
            end
            for (int i = 1; i <= CO_STEPS; i++)
            begin
                co_fl_reg[i] <= co_fl_reg[i-1];
                for (int l = 0; l < LANES; l++)
                begin
                    co_x_reg[i][l] <= co_x_next[i][l];
                    co_y_reg[i][l] <= co_y_next[i][l];
                    co_z_reg[i][l] <= co_z_next[i][l];
                end
            end

            out_data_reg <= {3'b000, roll_next, yaw_next, pitch_next};
            out_err_reg  <= err_next;
        end
    end

    // ------------------------------------------------------- assertions
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= OUT_FULL90 &&
                      $signed(m_tdata[14:0]) >= -OUT_FULL90))
        else $error("pitch out of range");

    a_czero_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sr_v_reg[0] && sr_fl_reg[0].czero |->
            (sr_rem_reg[0][1] == 29'd0 && sr_rem_reg[0][2] == 29'd0))
        else $error("side operand not cleared on zero cosine");

    a_pitch_operand: assert property (@(posedge clk) disable iff (!rst_n)
        sr_v_reg[0] |-> ({3'b000, sr_rem_reg[0][0]} <= ONE_SQ))
        else $error("pitch operand above one");

    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && !m_tready |=> m_tvalid && !m_tuser)
        else $error("error flag changed during stall");

endmodule

// ===== tb/dcm_to_euler_angles_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcm_to_euler_angles_tb
// Self-checking bench for the direction-cosine to Euler angle converter.
// Sends matrix entries over the input stream under several idling mixes and
// checks every angle triple and error flag against an in-bench predictor.
// ----------------------------------------------------------------------------
module dcm_to_euler_angles_tb;
    import dcm_pkg::*;

    typedef struct packed {
        logic signed [14:0] pitch;
        logic signed [14:0] yaw;
        logic signed [14:0] roll;
        logic               derr;
    } angles_t;

    localparam int LATENCY     = 35;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // r_row0_col2, r_row0_col1, r_row1_col2
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pitch_deg, yaw_deg, roll_deg, zero pad
    logic        m_tuser;   // domain_error

    angles_t angles_q[$];
    int      mismatches;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;
    bit      timed_out;

    dcm_to_euler_angles dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: exact integer arithmetic mirroring the fixed-point spec
    // ------------------------------------------------------------------
    function automatic longint isqrt(longint n);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // atan2(ny, nx) for non-negative operands, in 1/128 degree
    function automatic longint cordic_angle(longint ny, longint nx);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = nx <<< PRESCALE_BITS;
        y = ny <<< PRESCALE_BITS;
        z = 0;
        for (int i = 0; i < CO_STEPS; i++)
        begin
            // arithmetic shift on signed longint is a floor shift
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(ACC_FULL90)) z = longint'(ACC_FULL90);
        return (z + 16) >>> 5;
    endfunction

    function automatic longint side_angle(longint e, longint rest, ref bit derr);
        longint mag;
        longint a;
        mag = (e < 0) ? -e : e;
        if (rest < 0 || mag * mag > rest)
        begin
            derr = 1'b1;
            return (e >= 0) ? longint'(OUT_FULL90) : -longint'(OUT_FULL90);
        end
        a = cordic_angle(mag, isqrt(rest - mag * mag));
        return (e < 0) ? -a : a;
    endfunction

    function automatic angles_t predict_angles(logic signed [15:0] r02,
                                               logic signed [15:0] r01,
                                               logic signed [15:0] r12);
        longint  one_sq;
        longint  m02;
        longint  sq02;
        longint  p;
        longint  yw;
        longint  rl;
        longint  a;
        bit      derr;
        angles_t res;
        one_sq = longint'(ONE_SQ);
        m02 = (r02 < 0) ? -longint'(r02) : longint'(r02);
        sq02 = m02 * m02;
        derr = 1'b0;
        if (sq02 > one_sq)
        begin
            derr = 1'b1;
            p = (r02 > 0) ? -longint'(OUT_FULL90) : longint'(OUT_FULL90);
        end
        else
        begin
            a = cordic_angle(m02, isqrt(one_sq - sq02));
            p = (r02 < 0) ? a : -a;
        end
        if (sq02 >= one_sq)
        begin
            derr = 1'b1;
            yw = (r01 >= 0) ? longint'(OUT_FULL90) : -longint'(OUT_FULL90);
            rl = (r12 >= 0) ? longint'(OUT_FULL90) : -longint'(OUT_FULL90);
        end
        else
        begin
            yw = side_angle(longint'(r01), one_sq - sq02, derr);
            rl = side_angle(longint'(r12), one_sq - sq02, derr);
        end
        res.pitch = p[14:0];
        res.yaw   = yw[14:0];
        res.roll  = rl[14:0];
        res.derr  = derr;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request per call, changes on the falling edge; valid
    // stays up into the next call and drops only while idling
    // ------------------------------------------------------------------
    task automatic send_request(logic [15:0] r02, logic [15:0] r01, logic [15:0] r12);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r12, r01, r02};
        // wait for acceptance at a rising edge
        do @(posedge clk); while (!s_tready);
        angles_q.push_back(predict_angles(r02, r01, r12));
        @(negedge clk);
    endtask

    // entry drawn mostly inside the unit range, with edges and wild values
    function automatic logic [15:0] pick_entry();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 16'($signed($urandom_range(32768)) - 16384);
        if (sel < 80) return 16'($signed($urandom_range(64)) + 16320);
        if (sel < 90) return 16'(-16384 + $signed($urandom_range(64)));
        return 16'($urandom);
    endfunction

    // well-formed item: yaw and roll entries stay within cos(pitch)
    task automatic send_valid_orientation();
        int     r02;
        int     lim;
        int     r01;
        int     r12;
        r02 = $signed($urandom_range(32766)) - 16383;
        lim = int'(isqrt(longint'(ONE_SQ) - longint'(r02) * r02));
        r01 = $signed($urandom_range(2 * lim)) - lim;
        r12 = $signed($urandom_range(2 * lim)) - lim;
        send_request(16'(r02), 16'(r01), 16'(r12));
    endtask

    // ------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        angles_t got;
        angles_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[14:0], m_tdata[29:15], m_tdata[44:30], m_tuser};
            if (angles_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result p=%0d y=%0d r=%0d e=%0b",
                             got.pitch, got.yaw, got.roll, got.derr);
            end
            else
            begin
                want = angles_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp p=%0d y=%0d r=%0d e=%0b  got p=%0d y=%0d r=%0d e=%0b",
                                 want.pitch, want.yaw, want.roll, want.derr,
                                 got.pitch, got.yaw, got.roll, got.derr);
                end
            end
        end
    end

    // receiver stalls at random, or holds off entirely on request
    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // watchdog: count cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
        if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_extremes();
        logic [15:0] vals [5] = '{16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000};
        foreach (vals[i])
            send_request(vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5]);
        // exactly-one arguments for yaw and roll, no error expected
        send_request(16'd0, 16'h4000, 16'hC000);
        // pitch just inside unit, entries just past cos(pitch), then just within it
        send_request(16'h3FFF, 16'd200, 16'hFF38);
        send_request(16'hC001, 16'd181, 16'hFF4B);
        // pitch beyond one, both signs
        send_request(16'h4001, 16'd5, 16'hFFFB);
        send_request(16'hBFFF, 16'hFFFB, 16'd5);
        // yaw beyond one, roll fine, and the reverse
        send_request(16'd8192, 16'h3F00, 16'd100);
        send_request(16'd8192, 16'd100, 16'hC100);
        send_request(16'd1, 16'hFFFF, 16'd1);
        send_request(16'h5555, 16'hAAAA, 16'h1234);
    endtask

    task automatic test_random_phase(int count, int s_pct, int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
                send_valid_orientation();
            else
                send_request(pick_entry(), pick_entry(), pick_entry());
        end
    endtask

    // hold the receiver off long enough to fill the pipeline
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++) send_valid_orientation();
                s_tvalid <= 1'b0;
            end
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        timed_out = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        fork
            begin
                test_directed_extremes();
                test_random_phase(450, 0, 0);
                test_random_phase(450, 64, 0);
                test_random_phase(450, 0, 64);
                test_random_phase(450, 16, 16);
                test_backpressure();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                while (angles_q.size() != 0 && !timed_out) @(negedge clk);
                repeat (LATENCY + 10) @(negedge clk);
            end
            wait (timed_out);
        join_any
        disable fork;

        if (!timed_out && mismatches == 0 && angles_q.size() == 0)
            $display("dcm_to_euler_angles: match");
        else
            $display("dcm_to_euler_angles: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dcm_pkg.sv
sv/dcm_to_euler_angles.sv
tb/dcm_to_euler_angles_tb.sv
